// File: rtl/modular_exponentiation_assert.svh
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

`ifndef SYNTHESIS
`define MEXP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MEXP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MEXP_ASSERT(lbl, clk, rst_n, prop, msg)
`define MEXP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// File: rtl/mexp_pkg.sv
// Package with types and constants of the modular exponentiation block.
`timescale 1ns / 1ps
package mexp_pkg;

	localparam int DATA_W = 63;
	localparam int RES_W  = 30;
	localparam int Z_W    = 61;
	localparam int R_W    = 32;

	localparam logic [RES_W-1:0] PRIME     = 30'd1000000007;
	localparam logic [R_W-1:0]   PRIME_R   = 32'd1000000007;
	localparam logic [R_W-1:0]   PRIME2_R  = 32'd2000000014;
	localparam logic [R_W-1:0]   PRIME3_R  = 32'd3000000021;
	localparam logic [RES_W-1:0] ONE_RES   = 30'd1;
	localparam logic [RES_W:0]   SHIFT_MUL = 31'h4000_0000;

	// Barrett constant floor(2^61 / P); it fits in 32 bits.
	localparam logic [63:0]    MU_WIDE = (64'd1 << 61) / 64'd1000000007;
	localparam logic [R_W-1:0] MU      = MU_WIDE[R_W-1:0];

	typedef enum logic [2:0] {
		OP_NONE,
		OP_RED_HI,
		OP_RED_LO,
		OP_SQR,
		OP_MUL
	} mm_op_t;

	typedef enum logic {
		DEST_POW,
		DEST_ACC
	} mm_dest_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RED_HI,
		S_WAIT_HI,
		S_RED_LO,
		S_WAIT_LO,
		S_ROUND,
		S_MUL,
		S_WAIT_RND,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic   load;
		mm_op_t op;
		logic   shift_exp;
		logic   load_out;
	} mexp_cmd_t;

	typedef struct packed {
		logic exp_zero;
		logic exp_lsb;
		logic mm_busy;
	} mexp_status_t;

endpackage

// File: rtl/mexp_modmul.sv
// Pipelined modular multiply-add unit: (x * y + add) mod P by Barrett reduction.
`timescale 1ns / 1ps
`include "modular_exponentiation_assert.svh"
module mexp_modmul import mexp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op_valid,
	input  mm_dest_t         op_dest,
	input  logic [RES_W-1:0] op_x,
	input  logic [RES_W:0]   op_y,
	input  logic [RES_W-1:0] op_add,
	output logic             busy,
	output logic             res_valid,
	output mm_dest_t         res_dest,
	output logic [RES_W-1:0] res
);

	logic [Z_W-1:0] z_c;
	logic [Z_W-1:0] z_s1;
	logic [63:0]    qprod;
	logic [R_W-1:0] q_s2;
	logic [R_W-1:0] zl_s2;
	logic [R_W-1:0] qp_lo;
	logic [R_W-1:0] r_s3;
	logic [R_W-1:0] r_fix;
	logic           v_s1, v_s2, v_s3;
	mm_dest_t       d_s1, d_s2, d_s3;

	assign z_c   = Z_W'(op_x) * Z_W'(op_y) + Z_W'(op_add);
	assign qprod = 64'(z_s1[Z_W-1:Z_W-R_W]) * 64'(MU);
	assign qp_lo = R_W'(q_s2 * PRIME_R);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= op_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		z_s1  <= z_c;
		d_s1  <= op_dest;
		q_s2  <= qprod[63:32];
		zl_s2 <= z_s1[R_W-1:0];
		d_s2  <= d_s1;
		r_s3  <= zl_s2 - qp_lo;
		d_s3  <= d_s2;
	end

	// The quotient estimate is at most two below the true quotient.
	always_comb begin
		if (r_s3 >= PRIME2_R) begin
			r_fix = r_s3 - PRIME2_R;
		end else if (r_s3 >= PRIME_R) begin
			r_fix = r_s3 - PRIME_R;
		end else begin
			r_fix = r_s3;
		end
	end

	assign res       = r_fix[RES_W-1:0];
	assign res_valid = v_s3;
	assign res_dest  = d_s3;
	assign busy      = v_s1 | v_s2 | v_s3;

	`MEXP_ASSERT(a_rem_range, clk, arst_n, v_s3 |-> (r_s3 < PRIME3_R), "Barrett remainder out of range")
	`MEXP_ASSERT(a_res_reduced, clk, arst_n, v_s3 |-> (r_fix < PRIME_R), "Result not reduced")

endmodule

// File: rtl/mexp_datapath.sv
// Datapath: operand registers, exponent shifter, modular unit and output register.
`timescale 1ns / 1ps
module mexp_datapath import mexp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mexp_cmd_t         cmd,
	input  logic [DATA_W-1:0] base,
	input  logic [DATA_W-1:0] exponent,
	output mexp_status_t      st,
	output logic [RES_W-1:0]  result
);

	logic [DATA_W-1:0] base_q;
	logic [DATA_W-1:0] exp_q;
	logic [RES_W-1:0]  acc_q;
	logic [RES_W-1:0]  pow_q;
	logic [RES_W-1:0]  res_q;
	logic [RES_W-1:0]  mm_x;
	logic [RES_W:0]    mm_y;
	logic [RES_W-1:0]  mm_add;
	mm_dest_t          mm_dest;
	logic              mm_busy;
	logic              mm_res_valid;
	mm_dest_t          mm_res_dest;
	logic [RES_W-1:0]  mm_res;

	always_comb begin
		mm_x    = pow_q;
		mm_y    = {1'b0, pow_q};
		mm_add  = '0;
		mm_dest = DEST_POW;
		case (cmd.op)
			OP_RED_HI: begin
				mm_x   = RES_W'(base_q[DATA_W-1:2*RES_W]);
				mm_y   = SHIFT_MUL;
				mm_add = base_q[2*RES_W-1:RES_W];
			end
			OP_RED_LO: begin
				mm_y   = SHIFT_MUL;
				mm_add = base_q[RES_W-1:0];
			end
			OP_MUL: begin
				mm_x    = acc_q;
				mm_dest = DEST_ACC;
			end
			default: begin
			end
		endcase
	end

	mexp_modmul u_modmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (cmd.op != OP_NONE),
		.op_dest   (mm_dest),
		.op_x      (mm_x),
		.op_y      (mm_y),
		.op_add    (mm_add),
		.busy      (mm_busy),
		.res_valid (mm_res_valid),
		.res_dest  (mm_res_dest),
		.res       (mm_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= base;
			exp_q  <= exponent;
			acc_q  <= ONE_RES;
		end
		if (cmd.shift_exp) begin
			exp_q <= exp_q >> 1;
		end
		if (mm_res_valid) begin
			if (mm_res_dest == DEST_ACC) begin
				acc_q <= mm_res;
			end else begin
				pow_q <= mm_res;
			end
		end
		if (cmd.load_out) begin
			res_q <= acc_q;
		end
	end

	assign st.exp_zero = (exp_q == '0);
	assign st.exp_lsb  = exp_q[0];
	assign st.mm_busy  = mm_busy;
	assign result      = res_q;

endmodule

// File: rtl/mexp_ctrl.sv
// Controller state machine sequencing base reduction and square-and-multiply rounds.
`timescale 1ns / 1ps
`include "modular_exponentiation_assert.svh"
module mexp_ctrl import mexp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         out_ready,
	input  mexp_status_t st,
	output logic         in_ready,
	output logic         out_valid,
	output mexp_cmd_t    cmd
);

	state_t state_q, state_nxt;
	logic   out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_RED_HI;
				end
			end
			S_RED_HI: state_nxt = S_WAIT_HI;
			S_WAIT_HI: begin
				if (!st.mm_busy) begin
					state_nxt = S_RED_LO;
				end
			end
			S_RED_LO: state_nxt = S_WAIT_LO;
			S_WAIT_LO: begin
				if (!st.mm_busy) begin
					state_nxt = S_ROUND;
				end
			end
			S_ROUND: begin
				if (st.exp_zero) begin
					state_nxt = S_FINISH;
				end else if (st.exp_lsb) begin
					state_nxt = S_MUL;
				end else begin
					state_nxt = S_WAIT_RND;
				end
			end
			S_MUL: state_nxt = S_WAIT_RND;
			S_WAIT_RND: begin
				if (!st.mm_busy) begin
					state_nxt = S_ROUND;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '{load: 1'b0, op: OP_NONE, shift_exp: 1'b0, load_out: 1'b0};
		case (state_q)
			S_IDLE:     cmd.load = in_valid;
			S_RED_HI:   cmd.op = OP_RED_HI;
			S_RED_LO:   cmd.op = OP_RED_LO;
			S_ROUND: begin
				if (!st.exp_zero) begin
					cmd.op = OP_SQR;
				end
			end
			S_MUL:      cmd.op = OP_MUL;
			S_WAIT_RND: cmd.shift_exp = !st.mm_busy;
			S_FINISH:   cmd.load_out = !out_valid_q || out_ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	`MEXP_ASSERT(a_round_drained, clk, arst_n, (state_q == S_ROUND) |-> !st.mm_busy, "Round started with products in flight")
	`MEXP_ASSERT(a_finish_exp, clk, arst_n, (state_q == S_FINISH) |-> st.exp_zero, "Finished with exponent bits left")
	`MEXP_ASSERT_NEVER(a_load_busy, clk, arst_n, cmd.load && st.mm_busy, "Transaction loaded while unit busy")

endmodule

// File: rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: base^exponent mod 1000000007.
// The input channel (in_valid, in_ready, base, exponent) carries one transaction
// per computation; the output channel (out_valid, out_ready, result) returns one
// 30-bit residue per input transaction, in order.
// The base is first reduced in two multiply-add passes through a three-stage
// pipelined Barrett multiplier. Then each exponent bit, least significant first,
// takes one round: the power is squared and, for a set bit, the accumulator is
// multiplied by the power, both issued back to back into the same multiplier.
// The multiplier pipeline depth sets the round length, which is longer for a set
// bit than for a clear bit. One transaction is processed at a time.
// A finished result sits in an output register, so the next transaction is
// accepted while it waits; if the receiver still stalls when that next result
// is ready, the block holds it until the register frees.
// Reset clears the controller, the output valid flag and the multiplier valid bits; other registers are not reset.
`timescale 1ns / 1ps
module modular_exponentiation import mexp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] base,
	input  logic [DATA_W-1:0] exponent,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [RES_W-1:0]  result
);

	mexp_cmd_t    cmd;
	mexp_status_t st;

	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.st        (st),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	mexp_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.base     (base),
		.exponent (exponent),
		.st       (st),
		.result   (result)
	);

endmodule
